// ===== rtl/rds_pkg.sv =====
// ----------------------------------------------------------------------------
// rds_pkg
// Shared types, constants and the 32-bit clip helper for the reaction-diffusion
// sensitivity stencil.
// ----------------------------------------------------------------------------
package rds_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH   = 2;
  // four products of at most 2^62 each, summed exactly
  localparam int ACC_W         = 67;
  localparam int CLIP_W        = 72;
  localparam int REG_INDEX_W   = 2;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_COUPLING_X = 2'd0,
    REG_COUPLING_Y = 2'd1,
    REG_B_VALUE    = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [30:0]              coupling_x;
    logic [30:0]              coupling_y;
    logic signed [DATA_W-1:0] b_value;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] sx;
    logic signed [DATA_W-1:0] sy;
    logic                     last;
  } point_t;

  // one stencil evaluation: center point plus left/right sensitivities
  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] sx;
    logic signed [DATA_W-1:0] sy;
    logic signed [DATA_W-1:0] lx;
    logic signed [DATA_W-1:0] ly;
    logic signed [DATA_W-1:0] rx;
    logic signed [DATA_W-1:0] ry;
    logic                     last;
  } job_t;

  typedef struct packed {
    logic                     flag;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  localparam logic signed [CLIP_W-1:0] CLIP_MAX = CLIP_W'(64'sh7FFF_FFFF);
  localparam logic signed [CLIP_W-1:0] CLIP_MIN = -CLIP_MAX - CLIP_W'(1);

  function automatic sat_t clip32(input logic signed [CLIP_W-1:0] v);
    sat_t r;
    r.flag = 1'b0;
    r.val  = v[DATA_W-1:0];
    if (v > CLIP_MAX) begin
      r.flag = 1'b1;
      r.val  = CLIP_MAX[DATA_W-1:0];
    end else if (v < CLIP_MIN) begin
      r.flag = 1'b1;
      r.val  = CLIP_MIN[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/rds_queue.sv =====
// ----------------------------------------------------------------------------
// rds_queue
// Short job queue between the window front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module rds_queue #(
  parameter int DEPTH = rds_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rds_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output rds_pkg::job_t  pop_job,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rds_pkg::job_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  assert property (@(posedge clk) disable iff (rst) !(push && full) && !(pop && empty))
    else $error("queue overrun or underrun");

endmodule

// ===== rtl/rds_front.sv =====
// ----------------------------------------------------------------------------
// rds_front
// Three-point window: holds the pending point and its left sensitivities,
// issues one job per point; a last point after others is issued as a flush job.
// ----------------------------------------------------------------------------
module rds_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rds_pkg::point_t in_point,
  output logic            push,
  output rds_pkg::job_t   push_job,
  input  logic            q_full
);

  logic                                have_held;
  logic                                flush_pending;
  logic signed [rds_pkg::DATA_W-1:0]   held_x;
  logic signed [rds_pkg::DATA_W-1:0]   held_y;
  logic signed [rds_pkg::DATA_W-1:0]   held_sx;
  logic signed [rds_pkg::DATA_W-1:0]   held_sy;
  logic signed [rds_pkg::DATA_W-1:0]   left_sx;
  logic signed [rds_pkg::DATA_W-1:0]   left_sy;
  logic                                accept;

  assign in_ready = !flush_pending && !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    push          = 1'b0;
    push_job      = '0;
    push_job.lx   = left_sx;
    push_job.ly   = left_sy;
    if (flush_pending) begin
      // last point of the vector, right boundary is zero
      push          = !q_full;
      push_job.x    = held_x;
      push_job.y    = held_y;
      push_job.sx   = held_sx;
      push_job.sy   = held_sy;
      push_job.last = 1'b1;
    end else if (accept && have_held) begin
      push          = 1'b1;
      push_job.x    = held_x;
      push_job.y    = held_y;
      push_job.sx   = held_sx;
      push_job.sy   = held_sy;
      push_job.rx   = in_point.sx;
      push_job.ry   = in_point.sy;
    end else if (accept && in_point.last) begin
      // single-point vector: both neighbors zero
      push          = 1'b1;
      push_job.x    = in_point.x;
      push_job.y    = in_point.y;
      push_job.sx   = in_point.sx;
      push_job.sy   = in_point.sy;
      push_job.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_held     <= 1'b0;
      flush_pending <= 1'b0;
      held_x        <= '0;
      held_y        <= '0;
      held_sx       <= '0;
      held_sy       <= '0;
      left_sx       <= '0;
      left_sy       <= '0;
    end else if (flush_pending) begin
      if (!q_full) begin
        have_held     <= 1'b0;
        flush_pending <= 1'b0;
        held_x        <= '0;
        held_y        <= '0;
        held_sx       <= '0;
        held_sy       <= '0;
        left_sx       <= '0;
        left_sy       <= '0;
      end
    end else if (accept) begin
      if (have_held) begin
        left_sx <= held_sx;
        left_sy <= held_sy;
      end
      if (in_point.last && !have_held) begin
        have_held <= 1'b0;
      end else begin
        held_x        <= in_point.x;
        held_y        <= in_point.y;
        held_sx       <= in_point.sx;
        held_sy       <= in_point.sy;
        have_held     <= 1'b1;
        flush_pending <= in_point.last;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (accept && in_point.last && have_held) |=> flush_pending)
    else $error("flush not scheduled after last point");
  assert property (@(posedge clk) disable iff (rst)
    (flush_pending && !q_full) |=> (!flush_pending && !have_held && left_sx == '0))
    else $error("window not cleared after flush");

endmodule

// ===== rtl/rds_back.sv =====
// ----------------------------------------------------------------------------
// rds_back
// Sequenced arithmetic: one shared signed 32x32 multiplier forms xy, xx and
// the eight stencil products; Jacobian terms and sums are clipped to 32 bits.
// ----------------------------------------------------------------------------
module rds_back #(
  parameter int FRAC_BITS = rds_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rds_pkg::cfg_t                     cfg,
  input  logic                              job_valid,
  output logic                              job_pop,
  input  rds_pkg::job_t                     job,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rds_pkg::DATA_W-1:0] out_dsx,
  output logic signed [rds_pkg::DATA_W-1:0] out_dsy,
  output logic                              out_last,
  output logic                              out_sat
);

  localparam int DW   = rds_pkg::DATA_W;
  localparam int AW   = rds_pkg::ACC_W;
  localparam int CW   = rds_pkg::CLIP_W;
  localparam int RW   = 2 * DW - FRAC_BITS;
  localparam int JW   = RW + 2;

  localparam logic signed [2*DW-1:0] HALF_P = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [AW-1:0]   HALF_A = AW'(HALF_P);
  localparam logic signed [JW-1:0]   ONE_J  = JW'(64'sd1 <<< FRAC_BITS);

  typedef enum logic [11:0] {
    ST_XY   = 12'b0000_0000_0001,
    ST_XX   = 12'b0000_0000_0010,
    ST_CXL  = 12'b0000_0000_0100,
    ST_CXR  = 12'b0000_0000_1000,
    ST_JXX  = 12'b0000_0001_0000,
    ST_JXY  = 12'b0000_0010_0000,
    ST_CYL  = 12'b0000_0100_0000,
    ST_CYR  = 12'b0000_1000_0000,
    ST_JYY  = 12'b0001_0000_0000,
    ST_JYX  = 12'b0010_0000_0000,
    ST_SUMY = 12'b0100_0000_0000,
    ST_DONE = 12'b1000_0000_0000
  } step_t;

  logic                    busy;
  step_t                   step;
  rds_pkg::job_t           job_r;
  logic signed [2*DW-1:0]  preg;
  logic signed [RW-1:0]    xy;
  logic signed [RW-1:0]    xx;
  logic signed [DW-1:0]    jxx;
  logic signed [DW-1:0]    jxy;
  logic signed [DW-1:0]    jyy;
  logic signed [DW-1:0]    jyx;
  logic signed [AW-1:0]    accx;
  logic signed [AW-1:0]    accy;
  logic signed [DW-1:0]    dsx_r;
  logic                    sat_r;

  logic signed [DW-1:0]    cxs;
  logic signed [DW-1:0]    cys;
  logic signed [DW-1:0]    mul_a;
  logic signed [DW-1:0]    mul_b;
  logic signed [2*DW-1:0]  prod;
  logic signed [2*DW-1:0]  rnd_p;
  logic signed [JW-1:0]    jxx_w;
  logic signed [JW-1:0]    jyx_w;
  logic signed [JW-1:0]    jyy_w;
  logic signed [AW-1:0]    accx_rnd;
  logic signed [AW-1:0]    accy_rnd;
  logic signed [AW-1:0]    acc_prod;
  rds_pkg::sat_t           c_jxx;
  rds_pkg::sat_t           c_jyx;
  rds_pkg::sat_t           c_jxy;
  rds_pkg::sat_t           c_jyy;
  rds_pkg::sat_t           c_dx;
  rds_pkg::sat_t           c_dy;
  logic                    out_free;
  logic                    out_load;

  assign cxs = $signed({1'b0, cfg.coupling_x});
  assign cys = $signed({1'b0, cfg.coupling_y});

  always_comb begin
    unique case (step)
      ST_XY:   begin mul_a = job_r.x; mul_b = job_r.y;  end
      ST_XX:   begin mul_a = job_r.x; mul_b = job_r.x;  end
      ST_CXL:  begin mul_a = cxs;     mul_b = job_r.lx; end
      ST_CXR:  begin mul_a = cxs;     mul_b = job_r.rx; end
      ST_JXX:  begin mul_a = jxx;     mul_b = job_r.sx; end
      ST_JXY:  begin mul_a = jxy;     mul_b = job_r.sy; end
      ST_CYL:  begin mul_a = cys;     mul_b = job_r.ly; end
      ST_CYR:  begin mul_a = cys;     mul_b = job_r.ry; end
      ST_JYY:  begin mul_a = jyy;     mul_b = job_r.sy; end
      ST_JYX:  begin mul_a = jyx;     mul_b = job_r.sx; end
      default: begin mul_a = '0;      mul_b = '0;       end
    endcase
  end

  assign prod  = mul_a * mul_b;
  // round half up: add half an LSB, then floor
  assign rnd_p = (preg + HALF_P) >>> FRAC_BITS;

  assign jxx_w = (JW'(xy) <<< 1) - (JW'(cxs) <<< 1) - JW'(cfg.b_value) - ONE_J;
  assign jyx_w = JW'(cfg.b_value) - (JW'(xy) <<< 1);
  assign jyy_w = -(JW'(cys) <<< 1) - JW'(xx);

  assign c_jxx = rds_pkg::clip32(CW'(jxx_w));
  assign c_jyx = rds_pkg::clip32(CW'(jyx_w));
  assign c_jxy = rds_pkg::clip32(CW'(xx));
  assign c_jyy = rds_pkg::clip32(CW'(jyy_w));

  assign acc_prod = AW'(preg);
  assign accx_rnd = (accx + HALF_A) >>> FRAC_BITS;
  assign accy_rnd = (accy + HALF_A) >>> FRAC_BITS;
  assign c_dx     = rds_pkg::clip32(CW'(accx_rnd));
  assign c_dy     = rds_pkg::clip32(CW'(accy_rnd));

  assign out_free = !out_valid || out_ready;
  assign out_load = busy && (step == ST_DONE) && out_free;
  assign job_pop  = !busy && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= ST_XY;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (job_pop) begin
        busy <= 1'b1;
        step <= ST_XY;
      end else if (busy) begin
        if (step == ST_DONE) begin
          if (out_free) begin
            busy <= 1'b0;
          end
        end else begin
          // one-hot: advance by shifting
          step <= step_t'(step << 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    preg <= prod;
    if (job_pop) begin
      job_r <= job;
    end
    if (busy) begin
      unique case (step)
        ST_XY: begin
        end
        ST_XX: begin
          xy <= RW'(rnd_p);
        end
        ST_CXL: begin
          xx    <= RW'(rnd_p);
          jxx   <= c_jxx.val;
          jyx   <= c_jyx.val;
          sat_r <= c_jxx.flag | c_jyx.flag;
        end
        ST_CXR: begin
          accx  <= acc_prod;
          jxy   <= c_jxy.val;
          jyy   <= c_jyy.val;
          sat_r <= sat_r | c_jxy.flag | c_jyy.flag;
        end
        ST_JXX, ST_JXY, ST_CYL: begin
          accx <= accx + acc_prod;
        end
        ST_CYR: begin
          accy  <= acc_prod;
          dsx_r <= c_dx.val;
          sat_r <= sat_r | c_dx.flag;
        end
        ST_JYY, ST_JYX, ST_SUMY: begin
          accy <= accy + acc_prod;
        end
        ST_DONE: begin
          if (out_free) begin
            out_dsx  <= dsx_r;
            out_dsy  <= c_dy.val;
            out_last <= job_r.last;
            out_sat  <= sat_r | c_dy.flag;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) busy |-> $onehot(step))
    else $error("step register lost its one-hot code");
  assert property (@(posedge clk) disable iff (rst)
    (busy && step == ST_DONE && out_free) |=> (out_valid && !busy))
    else $error("finished result not loaded into the output register");

endmodule

// ===== rtl/reaction_diffusion_sensitivity_stencil.sv =====
// ----------------------------------------------------------------------------
// reaction_diffusion_sensitivity_stencil
// Jacobian-times-sensitivity of a 1-D two-species reaction-diffusion mesh,
// streamed one point per word, results lagging one point.
// ----------------------------------------------------------------------------
// A result passes through the queue write, 12 sequencer steps and the output
//   register after the word that completes its window arrives.
// The back end finishes one job before it pops the next, as the single shared 32x32
//   multiplier forms ten products per point; a last point after others yields two results.
// Input words are taken while the two-entry queue has room and no flush job is pending.
// Reset (rst, synchronous): clears the window, the queue pointers and the
//   configuration registers to zero and returns the sequencer to idle.
module reaction_diffusion_sensitivity_stencil #(
  parameter int FRAC_BITS = rds_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rds_pkg::REG_INDEX_W-1:0]     cfg_index,
  input  logic [rds_pkg::DATA_W-1:0]          cfg_data,
  // point stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [4*rds_pkg::DATA_W-1:0]        s_tdata,  // x_value, y_value, sens_x, sens_y
  input  logic                                s_tlast,  // last_point
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [2*rds_pkg::DATA_W-1:0]        m_tdata,  // dsx, dsy
  output logic                                m_tlast,  // last_result
  output logic                                m_tuser   // saturated
);

  localparam int DW = rds_pkg::DATA_W;

  rds_pkg::cfg_t                 cfg;
  rds_pkg::point_t               in_point;
  rds_pkg::job_t                 push_job;
  rds_pkg::job_t                 pop_job;
  logic                          push;
  logic                          pop;
  logic                          q_full;
  logic                          q_empty;
  logic signed [DW-1:0]          out_dsx;
  logic signed [DW-1:0]          out_dsy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rds_pkg::REG_COUPLING_X: cfg.coupling_x <= cfg_data[30:0];
        rds_pkg::REG_COUPLING_Y: cfg.coupling_y <= cfg_data[30:0];
        rds_pkg::REG_B_VALUE:    cfg.b_value    <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  assign in_point.x    = $signed(s_tdata[DW-1:0]);
  assign in_point.y    = $signed(s_tdata[2*DW-1:DW]);
  assign in_point.sx   = $signed(s_tdata[3*DW-1:2*DW]);
  assign in_point.sy   = $signed(s_tdata[4*DW-1:3*DW]);
  assign in_point.last = s_tlast;

  rds_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_point (in_point),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  rds_queue #(
    .DEPTH (rds_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  rds_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (!q_empty),
    .job_pop   (pop),
    .job       (pop_job),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_dsx   (out_dsx),
    .out_dsy   (out_dsy),
    .out_last  (m_tlast),
    .out_sat   (m_tuser)
  );

  assign m_tdata = {out_dsy, out_dsx};

endmodule
